// ----- hdl/text_console_cursor_engine_assert.svh -----
// Assertion macros used by the console engine back end.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// condition holds at every edge out of reset
`define TCCE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TCCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tcce_pkg.sv -----
// Types and constants of the text console cursor engine.
package tcce_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;
	localparam int Q_DEPTH  = 2;

	localparam logic [7:0] ATTR_RESET   = 8'h0F;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_CLEAR = 2'd1,
		MODE_MOVE  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_NEWLINE,
		CMD_RETURN,
		CMD_BACKSPACE,
		CMD_CLEAR,
		CMD_MOVE,
		CMD_READ,
		CMD_READ_OOR
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADDR,
		BK_FILL,
		BK_ACCESS,
		BK_UPDATE,
		BK_REPORT
	} back_state_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         char_code;
		logic signed [7:0]  delta;
		logic [4:0]         read_row;
		logic [6:0]         read_col;
	} cmd_in_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_pos;
		logic [15:0] cell_word;
		logic        scrolled;
	} result_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [7:0]         char_code;
		logic signed [7:0]  delta;
		logic [4:0]         read_row;
		logic [6:0]         read_col;
	} cmd_t;

endpackage

// ----- hdl/tcce_front.sv -----
// Front end: takes command words and classifies them for the queue.
module tcce_front #(
	parameter int COLS = tcce_pkg::DEF_COLS,
	parameter int ROWS = tcce_pkg::DEF_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  tcce_pkg::cmd_in_t cmd,
	output logic             busy,
	input  logic             full,
	output logic             push,
	output tcce_pkg::cmd_t   push_data
);
	import tcce_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_t      cls;
	logic      accept;
	logic      out_of_range;

	assign push      = valid_s1 && !full;
	assign busy      = valid_s1 && full;
	assign accept    = start && !busy;
	assign push_data = cmd_s1;

	assign out_of_range = (9'(cmd.read_row) >= 9'(ROWS)) || (9'(cmd.read_col) >= 9'(COLS));

	always_comb begin
		cls.char_code = cmd.char_code;
		cls.delta     = cmd.delta;
		cls.read_row  = cmd.read_row;
		cls.read_col  = cmd.read_col;
		case (cmd.mode)
			MODE_PUT: begin
				if (cmd.char_code == CH_NEWLINE)
					cls.kind = CMD_NEWLINE;
				else if (cmd.char_code == CH_RETURN)
					cls.kind = CMD_RETURN;
				else if (cmd.char_code == CH_BACKSPACE)
					cls.kind = CMD_BACKSPACE;
				else
					cls.kind = CMD_PRINT;
			end
			MODE_CLEAR: cls.kind = CMD_CLEAR;
			MODE_MOVE:  cls.kind = CMD_MOVE;
			MODE_READ:  cls.kind = out_of_range ? CMD_READ_OOR : CMD_READ;
			default:    cls.kind = CMD_READ_OOR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// ----- hdl/tcce_queue.sv -----
// Short command queue between front end and back end.
module tcce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcce_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output tcce_pkg::cmd_t head,
	output logic           empty
);
	import tcce_pkg::*;

	localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	cmd_t           slots [Q_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] cnt_q;

	assign full  = cnt_q == QCW'(Q_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slots[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/tcce_back.sv -----
// Back end: cursor state, circular row store and result generation.
`include "text_console_cursor_engine_assert.svh"
module tcce_back #(
	parameter int COLS = tcce_pkg::DEF_COLS,
	parameter int ROWS = tcce_pkg::DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcce_pkg::cmd_t    head,
	input  logic              empty,
	output logic              pop,
	input  logic [7:0]        attr,
	output logic              done,
	output tcce_pkg::result_t result
);
	import tcce_pkg::*;

	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic is_mem_op(cmd_kind_t k);
		return (k == CMD_PRINT) || (k == CMD_BACKSPACE) || (k == CMD_READ);
	endfunction

	function automatic logic is_write_op(cmd_kind_t k);
		return (k == CMD_PRINT) || (k == CMD_BACKSPACE);
	endfunction

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [RW-1:0]   top_q;
	logic [ROWS-1:0] row_valid_q;
	logic [RW-1:0]   mrow_q;
	logic [CW-1:0]   mcol_q;
	logic [AW-1:0]   base_q;
	logic [CW-1:0]   fill_q;
	logic            rvalid_q;
	logic [7:0]      rdata_q;
	logic [15:0]     cell_q;
	logic            scrolled_q;
	logic            done_q;
	result_t         result_q;

	logic [7:0] store_mem [DEPTH];

	// physical row/column of the cell touched by the queue head
	logic [CW-1:0] bs_col;
	logic [8:0]    lrow;
	logic [8:0]    lcol;
	logic [8:0]    psum;
	logic [8:0]    prow;

	logic          last_fill;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;

	logic [8:0]        upd_col;
	logic [8:0]        upd_row;
	logic signed [9:0] mv;
	logic [8:0]        top_inc;
	logic [15:0]       pos_full;

	assign bs_col = (col_q != '0) ? col_q - 1'b1 : col_q;
	assign lrow   = (head.kind == CMD_READ) ? 9'(head.read_row) : 9'(row_q);
	assign lcol   = (head.kind == CMD_READ) ? 9'(head.read_col) :
			(head.kind == CMD_BACKSPACE) ? 9'(bs_col) : 9'(col_q);
	assign psum   = lrow + 9'(top_q);
	assign prow   = (psum >= 9'(ROWS)) ? psum - 9'(ROWS) : psum;

	assign last_fill = fill_q == CW'(COLS - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!empty)
					state_d = is_mem_op(head.kind) ? BK_ADDR : BK_UPDATE;
			end
			BK_ADDR: begin
				if (is_write_op(cmd_q.kind) && !row_valid_q[mrow_q])
					state_d = BK_FILL;
				else
					state_d = BK_ACCESS;
			end
			BK_FILL:   if (last_fill) state_d = BK_ACCESS;
			BK_ACCESS: state_d = BK_UPDATE;
			BK_UPDATE: state_d = BK_REPORT;
			BK_REPORT: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == BK_IDLE) && !empty;
		mem_we    = (state_q == BK_FILL) ||
			((state_q == BK_ACCESS) && is_write_op(cmd_q.kind));
		mem_addr  = (state_q == BK_FILL) ? base_q + AW'(fill_q) : base_q + AW'(mcol_q);
		mem_wdata = ((state_q == BK_FILL) || (cmd_q.kind == CMD_BACKSPACE)) ?
			BLANK_CHAR : cmd_q.char_code;
	end

	// cursor after the current command, before the scroll check
	always_comb begin
		upd_col = 9'(col_q);
		upd_row = 9'(row_q);
		mv      = $signed({1'b0, 9'(col_q)}) + 10'(cmd_q.delta);
		case (cmd_q.kind)
			CMD_PRINT: begin
				if (9'(col_q) + 9'd1 >= 9'(COLS)) begin
					upd_col = '0;
					upd_row = 9'(row_q) + 9'd1;
				end else begin
					upd_col = 9'(col_q) + 9'd1;
				end
			end
			CMD_NEWLINE: begin
				upd_col = '0;
				upd_row = 9'(row_q) + 9'd1;
			end
			CMD_RETURN:    upd_col = '0;
			CMD_BACKSPACE: upd_col = 9'(mcol_q);
			CMD_CLEAR: begin
				upd_col = '0;
				upd_row = '0;
			end
			CMD_MOVE: begin
				if (mv < 10'sd0)
					upd_col = '0;
				else if (mv >= $signed(10'(COLS)))
					upd_col = 9'(COLS - 1);
				else
					upd_col = mv[8:0];
			end
			default: ;
		endcase
	end

	assign top_inc  = 9'(top_q) + 9'd1;
	assign pos_full = 16'(row_q * COLS) + 16'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			row_valid_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == BK_REPORT;
			if (state_q == BK_FILL && last_fill) begin
				row_valid_q[mrow_q] <= 1'b1;
			end
			if (state_q == BK_UPDATE) begin
				col_q <= upd_col[CW-1:0];
				if (cmd_q.kind == CMD_CLEAR) begin
					row_q       <= '0;
					top_q       <= '0;
					row_valid_q <= '0;
				end else if (upd_row >= 9'(ROWS)) begin
					row_q              <= RW'(ROWS - 1);
					top_q              <= (top_inc == 9'(ROWS)) ? '0 : top_inc[RW-1:0];
					row_valid_q[top_q] <= 1'b0;
				end else begin
					row_q <= upd_row[RW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			mrow_q <= prow[RW-1:0];
			mcol_q <= lcol[CW-1:0];
		end
		if (state_q == BK_ADDR) begin
			base_q   <= AW'(mrow_q * COLS);
			rvalid_q <= row_valid_q[mrow_q];
			fill_q   <= '0;
		end
		if (state_q == BK_FILL) begin
			fill_q <= fill_q + 1'b1;
		end
		if (state_q == BK_UPDATE) begin
			scrolled_q <= (cmd_q.kind != CMD_CLEAR) && (upd_row >= 9'(ROWS));
			cell_q     <= (cmd_q.kind == CMD_READ) ?
				{attr, (rvalid_q ? rdata_q : BLANK_CHAR)} : 16'd0;
		end
		if (state_q == BK_REPORT) begin
			result_q.cursor_col <= 7'(col_q);
			result_q.cursor_row <= 5'(row_q);
			result_q.cursor_pos <= pos_full[10:0];
			result_q.cell_word  <= cell_q;
			result_q.scrolled   <= scrolled_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= store_mem[mem_addr];
	end

	assign done   = done_q;
	assign result = result_q;

	`TCCE_ASSERT_ALWAYS(a_cursor_in_range, clk, arst_n, (9'(col_q) < 9'(COLS)) && (9'(row_q) < 9'(ROWS)), "cursor outside screen")
	`TCCE_ASSERT_ALWAYS(a_top_in_range, clk, arst_n, 9'(top_q) < 9'(ROWS), "top row pointer out of range")
	`TCCE_ASSERT_IMPL(a_fill_on_write, clk, arst_n, state_q == BK_FILL, is_write_op(cmd_q.kind), "row fill without a write")
	`TCCE_ASSERT_NEXT(a_one_strobe, clk, arst_n, done_q, !done_q, "result strobe longer than one cycle")
	`TCCE_ASSERT_NEXT(a_fill_marks_row, clk, arst_n, (state_q == BK_FILL) && last_fill, row_valid_q[mrow_q], "filled row not marked valid")

endmodule

// ----- hdl/text_console_cursor_engine.sv -----
// Top level of the text console cursor engine.
//
//  channel   handshake               payload
//  command   start / busy            cmd    (tcce_pkg::cmd_in_t)
//  result    done (1-cycle strobe)   result (tcce_pkg::result_t)
//  config    attr_we                 attr_wdata (text attribute byte)
//
// Put char, backspace and in-range reads pass address, access, update and report
// on the way to done, other commands only update and report; the front register
// and queue lie ahead of the back end. The first write into a row after a clear
// or scroll first blanks that row through the single store write port.
// Reset clears row valid bits and cursor state; no store clearing pass.
// The result side cannot stall; busy rises when front register and queue are full.
module text_console_cursor_engine #(
	parameter int COLS = tcce_pkg::DEF_COLS,
	parameter int ROWS = tcce_pkg::DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcce_pkg::cmd_in_t cmd,
	output logic              done,
	output tcce_pkg::result_t result,
	input  logic              attr_we,
	input  logic [7:0]        attr_wdata
);
	import tcce_pkg::*;

	logic       attr_q;
	logic [7:0] attr_val_q;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	cmd_t       q_in;
	cmd_t       q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_val_q <= ATTR_RESET;
			attr_q     <= 1'b0;
		end else begin
			attr_q <= attr_we;
			if (attr_we) begin
				attr_val_q <= attr_wdata;
			end
		end
	end

	tcce_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.full     (q_full),
		.push     (q_push),
		.push_data(q_in)
	);

	tcce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	tcce_back #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty || attr_q),
		.pop    (q_pop),
		.attr   (attr_val_q),
		.done   (done),
		.result (result)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the text console cursor engine.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcce_pkg::*;

	localparam int COLS  = DEF_COLS;
	localparam int ROWS  = DEF_ROWS;
	localparam int CMD_W = $bits(cmd_in_t);
	localparam int DRAIN = 2 * COLS + 20;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       start      = 1'b0;
	logic       busy;
	cmd_in_t    cmd        = '0;
	logic       done;
	result_t    result;
	logic       attr_we    = 1'b0;
	logic [7:0] attr_wdata = '0;

	always #5 clk = ~clk;

	text_console_cursor_engine #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.attr_we(attr_we),
		.attr_wdata(attr_wdata)
	);

	// shadow of the screen, cursor and attribute
	logic [7:0]  screen [ROWS*COLS];
	int unsigned cur_col;
	int unsigned cur_row;
	logic [7:0]  attr_shadow;
	result_t     awaited_results[$];

	int n_errors  = 0;
	int n_sent    = 0;
	int n_checked = 0;
	int n_scrolls = 0;
	int n_reads   = 0;
	int burst_left = 0;
	bit pacing_on  = 1'b0;

	function automatic void blank_screen();
		foreach (screen[i]) screen[i] = BLANK_CHAR;
		cur_col = 0;
		cur_row = 0;
	endfunction

	function automatic result_t predict_console_result(cmd_in_t c);
		result_t r;
		int      col_next;
		bit      scroll;
		r = '0;
		scroll = 1'b0;
		case (c.mode)
			MODE_PUT: begin
				if (c.char_code == CH_NEWLINE) begin
					cur_row++;
					cur_col = 0;
				end else if (c.char_code == CH_RETURN) begin
					cur_col = 0;
				end else if (c.char_code == CH_BACKSPACE) begin
					if (cur_col > 0) cur_col--;
					screen[cur_row*COLS + cur_col] = BLANK_CHAR;
				end else begin
					screen[cur_row*COLS + cur_col] = c.char_code;
					cur_col++;
				end
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i < (ROWS-1)*COLS; i++) screen[i] = screen[i+COLS];
					for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen[i] = BLANK_CHAR;
					cur_row = ROWS - 1;
					scroll = 1'b1;
				end
			end
			MODE_CLEAR: begin
				blank_screen();
			end
			MODE_MOVE: begin
				col_next = int'(cur_col) + int'(c.delta);
				if (col_next < 0) col_next = 0;
				else if (col_next >= COLS) col_next = COLS - 1;
				cur_col = col_next;
			end
			default: begin
				if (c.read_row < ROWS && c.read_col < COLS)
					r.cell_word = {attr_shadow, screen[c.read_row*COLS + c.read_col]};
			end
		endcase
		r.cursor_col = cur_col[6:0];
		r.cursor_row = cur_row[4:0];
		r.cursor_pos = 11'(cur_row*COLS + cur_col);
		r.scrolled   = scroll;
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result word with nothing expected");
				n_errors++;
			end else begin
				want = awaited_results.pop_front();
				n_checked++;
				if (want.scrolled) n_scrolls++;
				if (result.cursor_col !== want.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", want.cursor_col,
						result.cursor_col);
					n_errors++;
				end
				if (result.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", want.cursor_row,
						result.cursor_row);
					n_errors++;
				end
				if (result.cursor_pos !== want.cursor_pos) begin
					$error("cursor_pos: expected %0d, got %0d", want.cursor_pos,
						result.cursor_pos);
					n_errors++;
				end
				if (result.cell_word !== want.cell_word) begin
					$error("cell_word: expected %h, got %h", want.cell_word,
						result.cell_word);
					n_errors++;
				end
				if (result.scrolled !== want.scrolled) begin
					$error("scrolled: expected %0d, got %0d", want.scrolled,
						result.scrolled);
					n_errors++;
				end
			end
		end
	end

	// bursts with random gaps; start only drops when a real gap follows
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 16);
		gap = 0;
		if (pacing_on)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_word(cmd_in_t c);
		pace();
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy !== 1'b0);
		awaited_results.push_back(predict_console_result(c));
		n_sent++;
		if (c.mode == MODE_READ) n_reads++;
	endtask

	task automatic wait_idle(int extra);
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_attribute(logic [7:0] v);
		wait_idle(4);
		attr_we    <= 1'b1;
		attr_wdata <= v;
		@(posedge clk);
		attr_we     <= 1'b0;
		attr_shadow = v;
	endtask

	function automatic cmd_in_t random_word();
		return cmd_in_t'(CMD_W'($urandom));
	endfunction

	function automatic cmd_in_t put_word(logic [7:0] ch);
		cmd_in_t c;
		c = random_word();
		c.mode = MODE_PUT;
		c.char_code = ch;
		return c;
	endfunction

	function automatic cmd_in_t move_word(logic signed [7:0] d);
		cmd_in_t c;
		c = random_word();
		c.mode = MODE_MOVE;
		c.delta = d;
		return c;
	endfunction

	function automatic cmd_in_t read_word(logic [4:0] r, logic [6:0] col);
		cmd_in_t c;
		c = random_word();
		c.mode = MODE_READ;
		c.read_row = r;
		c.read_col = col;
		return c;
	endfunction

	function automatic cmd_in_t clear_word();
		cmd_in_t c;
		c = random_word();
		c.mode = MODE_CLEAR;
		return c;
	endfunction

	task automatic test_reset_state();
		send_word(read_word(5'd0, 7'd0));
		send_word(read_word(5'(ROWS-1), 7'(COLS-1)));
	endtask

	task automatic test_put_and_controls();
		send_word(put_word("H"));
		send_word(put_word(8'hFF));
		send_word(put_word(8'h00));
		send_word(put_word(CH_BACKSPACE));
		send_word(put_word(CH_BACKSPACE));
		send_word(put_word(CH_BACKSPACE));
		send_word(put_word(CH_BACKSPACE)); // at column 0: stays, blanks cell
		send_word(put_word("x"));
		send_word(put_word(CH_RETURN));
		send_word(put_word(CH_NEWLINE));
		send_word(read_word(5'd0, 7'd0));
		send_word(read_word(5'd0, 7'd1));
	endtask

	task automatic test_move_clamp();
		send_word(move_word(8'sd127));
		send_word(move_word(8'sd1));
		send_word(put_word("Z")); // wraps at line end
		send_word(move_word(-8'sd128));
	endtask

	task automatic test_read_out_of_range();
		send_word(read_word(5'(ROWS), 7'd0));
		send_word(read_word(5'd0, 7'(COLS)));
		send_word(read_word(5'h1F, 7'h7F));
	endtask

	task automatic test_attribute_change();
		write_attribute(8'hFF);
		send_word(read_word(5'd1, 7'd79));
		write_attribute(8'h00);
		send_word(read_word(5'd0, 7'd0));
	endtask

	task automatic test_clear();
		send_word(clear_word());
		send_word(read_word(5'd1, 7'd79));
	endtask

	function automatic logic [7:0] text_char();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) return CH_BACKSPACE;
		if (pick == 1) return CH_RETURN;
		if (pick == 2) return 8'($urandom);
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	task automatic random_phase(int n_items);
		int stop_at;
		int pick;
		int len;
		logic [4:0] r;
		logic [6:0] col;
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
					: $urandom_range(0, 20);
				repeat (len) send_word(put_word(text_char()));
				send_word(put_word(CH_NEWLINE));
			end else if (pick < 72) begin
				if ($urandom_range(0, 2) == 0) send_word(move_word(8'($urandom)));
				else send_word(move_word(8'($urandom_range(0, 16) - 8)));
			end else if (pick < 88) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 3))
						0: r = 5'(cur_row);
						1: r = 5'((cur_row + ROWS - 1) % ROWS);
						2: r = 5'($urandom_range(0, ROWS - 1));
						default: r = 5'($urandom);
					endcase
					col = ($urandom_range(0, 7) == 0) ? 7'($urandom)
						: 7'($urandom_range(0, COLS - 1));
					send_word(read_word(r, col));
				end
			end else if (pick < 90) begin
				send_word(clear_word());
			end else begin
				send_word(random_word());
			end
		end
	endtask

	task automatic test_random_traffic();
		write_attribute(8'h00);
		pacing_on = 1'b0;
		random_phase(150);
		write_attribute(8'hFF);
		pacing_on = 1'b1;
		random_phase(150);
		write_attribute(8'($urandom));
		random_phase(150);
		write_attribute(ATTR_RESET);
		random_phase(150);
	endtask

	initial begin
		blank_screen();
		attr_shadow = ATTR_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_put_and_controls();
		test_move_clamp();
		test_read_out_of_range();
		test_attribute_change();
		test_clear();
		test_random_traffic();

		wait_idle(DRAIN);
		$display("Sent %0d command words, checked %0d results.", n_sent, n_checked);
		$display("Covered %0d cell reads and %0d scrolls.", n_reads, n_scrolls);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_front.sv
hdl/tcce_queue.sv
hdl/tcce_back.sv
hdl/text_console_cursor_engine.sv
tb/testbench.sv
